### rtl/chrt_pkg.sv
// Package for the closest-hit ray/triangle caster.
// Holds widths, command codes, the per-triangle op sequence and small helpers.
// No dependencies; every rtl file uses it by scoped names.
package chrt_pkg;

  localparam int WORD_W        = 32;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_TRIANGLES = 256;
  localparam int WORDS_PER_TRI = 18;
  localparam int STORE_DEPTH   = MAX_TRIANGLES * WORDS_PER_TRI;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int TRI_W         = $clog2(MAX_TRIANGLES);
  localparam int CNT_W         = TRI_W + 1;
  localparam int WIDX_W        = 5;
  localparam int PROD_W        = 2 * WORD_W - FRAC_BITS;
  localparam int ACC_W         = PROD_W + 4;
  localparam int MAG_W         = ACC_W - 1;
  localparam int DEN_W         = ACC_W - 2;
  localparam int Q_W           = 31;
  localparam int COLOR_W       = 24;

  // Command codes carried by the input channel.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RAY  = 1'b1;

  // Steps of one triangle test, run in this order.
  typedef enum logic [4:0] {
    OP_NS0, OP_NV0, OP_NS1, OP_NV1, OP_NS2, OP_NV2,
    OP_D,
    OP_P0, OP_P1, OP_P2,
    OP_M00, OP_M01, OP_M02, OP_M10, OP_M11, OP_M12,
    OP_W10, OP_W11, OP_W20, OP_W21,
    OP_COLOR
  } op_e;

  // Word of the triangle record that a step reads.
  function automatic logic [WIDX_W-1:0] op_word(input op_e op);
    logic [WIDX_W-1:0] w;
    case (op)
      OP_NS0, OP_NV0: w = 5'd0;
      OP_NS1, OP_NV1: w = 5'd1;
      OP_NS2, OP_NV2: w = 5'd2;
      OP_D:           w = 5'd3;
      OP_P0:          w = 5'd4;
      OP_P1:          w = 5'd5;
      OP_P2:          w = 5'd6;
      OP_M00:         w = 5'd7;
      OP_M01:         w = 5'd8;
      OP_M02:         w = 5'd9;
      OP_M10:         w = 5'd10;
      OP_M11:         w = 5'd11;
      OP_M12:         w = 5'd12;
      OP_W10:         w = 5'd13;
      OP_W11:         w = 5'd14;
      OP_W20:         w = 5'd15;
      OP_W21:         w = 5'd16;
      default:        w = 5'd17;
    endcase
    return w;
  endfunction

  // Store address of one word: tri * 18 + word.
  function automatic logic [ADDR_W-1:0] tri_addr(input logic [TRI_W-1:0] t,
                                                 input logic [WIDX_W-1:0] w);
    return ADDR_W'({t, 4'b0000}) + ADDR_W'({t, 1'b0}) + ADDR_W'(w);
  endfunction

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sh7FFF_FFFF);
    lo = -ACC_W'(64'sh8000_0000);
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[WORD_W-1:0];
  endfunction

endpackage

### rtl/chrt_store.sv
// Triangle record store: one write port for loads, one registered read port.
// Depends on chrt_pkg for depth and widths.
module chrt_store (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [chrt_pkg::ADDR_W-1:0]  waddr_i,
  input  logic [chrt_pkg::WORD_W-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [chrt_pkg::ADDR_W-1:0]  raddr_i,
  output logic [chrt_pkg::WORD_W-1:0]  rdata_o
);

  logic [chrt_pkg::WORD_W-1:0] mem [0:chrt_pkg::STORE_DEPTH-1];
  logic [chrt_pkg::WORD_W-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/chrt_mul.sv
// Shared fixed-point multiplier: registered signed product, floored to Q format.
// Depends on chrt_pkg for widths.
module chrt_mul (
  input  logic                               clk_i,
  input  logic signed [chrt_pkg::WORD_W-1:0] a_i,
  input  logic signed [chrt_pkg::WORD_W-1:0] b_i,
  output logic signed [chrt_pkg::PROD_W-1:0] prod_o
);

  logic signed [2*chrt_pkg::WORD_W-1:0] full;
  logic signed [chrt_pkg::PROD_W-1:0]   prod_q;

  assign full = a_i * b_i;

  // Dropping the fraction bits of a two's complement value floors it.
  always_ff @(posedge clk_i) begin
    prod_q <= full[2*chrt_pkg::WORD_W-1:chrt_pkg::FRAC_BITS];
  end

  assign prod_o = prod_q;

endmodule

### rtl/chrt_div.sv
// Restoring divider for the hit distance: (a * 2^FRAC) / b, saturated to 31 bits.
// One quotient bit per cycle; depends on chrt_pkg for widths.
module chrt_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [chrt_pkg::MAG_W-1:0]       a_i,
  input  logic [chrt_pkg::DEN_W-1:0]       b_i,
  output logic                             done_o,
  output logic [chrt_pkg::Q_W-1:0]         quot_o
);

  localparam int XW = chrt_pkg::MAG_W + chrt_pkg::FRAC_BITS;

  logic [XW-1:0]                   x;
  logic [chrt_pkg::DEN_W-1:0]      b_q;
  logic [chrt_pkg::DEN_W-1:0]      rem_q;
  logic [chrt_pkg::Q_W-1:0]        low_q;
  logic [chrt_pkg::Q_W-1:0]        quot_q;
  logic [4:0]                      cnt_q;
  logic                            busy_q;
  logic                            done_q;
  logic [chrt_pkg::DEN_W:0]        trial;
  logic                            fits;

  assign x     = {a_i, {chrt_pkg::FRAC_BITS{1'b0}}};
  assign trial = {rem_q, low_q[chrt_pkg::Q_W-1]};
  assign fits  = trial >= {1'b0, b_q};

  // Start: detect saturation up front, else run 31 shift-subtract steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        b_q <= b_i;
        if (chrt_pkg::DEN_W'(x[XW-1:chrt_pkg::Q_W]) >= b_i) begin
          quot_q <= '1;
          done_q <= 1'b1;
        end else begin
          rem_q  <= chrt_pkg::DEN_W'(x[XW-1:chrt_pkg::Q_W]);
          low_q  <= x[chrt_pkg::Q_W-1:0];
          quot_q <= '0;
          cnt_q  <= 5'(chrt_pkg::Q_W);
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        if (fits) begin
          rem_q <= chrt_pkg::DEN_W'(trial - {1'b0, b_q});
        end else begin
          rem_q <= trial[chrt_pkg::DEN_W-1:0];
        end
        quot_q <= {quot_q[chrt_pkg::Q_W-2:0], fits};
        low_q  <= {low_q[chrt_pkg::Q_W-2:0], 1'b0};
        cnt_q  <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### rtl/closest_hit_ray_triangle_caster.sv
// Closest-hit ray/triangle caster: top level with the per-ray sequencer.
// Depends on chrt_pkg, chrt_store, chrt_mul and chrt_div.
//
// A ray transfer walks the first triangle_count triangles (at most 256) one after
// the other through a single shared multiplier fed from the single read port of
// the record store: every triangle runs the plane test, and one that passes it
// also runs the divider (which stops early when the depth saturates) and, for a
// nonzero depth, the barycentric check. The input is not ready while a ray is
// walked. The result sits in an output register, so the next item is taken while
// it waits.
module closest_hit_ray_triangle_caster (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [chrt_pkg::CNT_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [chrt_pkg::TRI_W-1:0]          tri_index_i,
  input  logic [chrt_pkg::WIDX_W-1:0]         word_index_i,
  input  logic signed [chrt_pkg::WORD_W-1:0]  word_value_i,
  input  logic signed [chrt_pkg::WORD_W-1:0]  origin_x_i,
  input  logic signed [chrt_pkg::WORD_W-1:0]  origin_y_i,
  input  logic signed [chrt_pkg::WORD_W-1:0]  origin_z_i,
  input  logic signed [chrt_pkg::WORD_W-1:0]  dir_x_i,
  input  logic signed [chrt_pkg::WORD_W-1:0]  dir_y_i,
  input  logic signed [chrt_pkg::WORD_W-1:0]  dir_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                hit_o,
  output logic [chrt_pkg::COLOR_W-1:0]        ray_color_o,
  output logic [chrt_pkg::Q_W-1:0]            depth_o
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_MUL  = 6'b000100,
    S_ACC  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  localparam int W  = chrt_pkg::WORD_W;
  localparam int AW = chrt_pkg::ACC_W;

  state_e                     state_q;
  chrt_pkg::op_e              op_q;
  logic [chrt_pkg::CNT_W-1:0] cfg_q;
  logic [chrt_pkg::CNT_W-1:0] tri_q;
  logic [chrt_pkg::CNT_W-1:0] tri_cnt_q;
  logic signed [W-1:0]        s_q [3];
  logic signed [W-1:0]        v_q [3];
  logic signed [W-1:0]        r_q [3];
  logic signed [AW-1:0]       num_q, den_q, m0_q, m1_q, w1_q, w2_q;
  logic [chrt_pkg::Q_W-1:0]   q_q;
  logic                       found_q;
  logic [chrt_pkg::Q_W-1:0]   best_q;
  logic [chrt_pkg::COLOR_W-1:0] color_q;
  logic                       out_valid_q;
  logic                       hit_q;
  logic [chrt_pkg::COLOR_W-1:0] out_color_q;
  logic [chrt_pkg::Q_W-1:0]   depth_q;

  logic                       in_xfer;
  logic                       store_we;
  logic [W-1:0]               rdata;
  logic signed [W-1:0]        word_s;
  logic signed [W-1:0]        mul_a, mul_b;
  logic signed [chrt_pkg::PROD_W-1:0] prod;
  logic signed [AW-1:0]       prod_x;
  logic signed [AW-1:0]       num_new;
  logic                       plane_ok;
  logic [chrt_pkg::MAG_W-1:0] div_a;
  logic [chrt_pkg::DEN_W-1:0] div_b;
  logic                       div_start;
  logic                       div_done;
  logic [chrt_pkg::Q_W-1:0]   div_q;
  logic signed [AW-1:0]       w0;
  logic                       inside_tri;
  logic                       last_tri;
  logic signed [W-1:0]        p_sat;
  logic [1:0]                 lane;
  logic                       out_load;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign store_we    = in_xfer && (command_i == chrt_pkg::CMD_LOAD) &&
                       (word_index_i < 5'(chrt_pkg::WORDS_PER_TRI));

  // Register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_data_i;
    end
  end

  chrt_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (chrt_pkg::tri_addr(tri_index_i, word_index_i)),
    .wdata_i (word_value_i),
    .re_i    (state_q == S_RD),
    .raddr_i (chrt_pkg::tri_addr(tri_q[chrt_pkg::TRI_W-1:0], chrt_pkg::op_word(op_q))),
    .rdata_o (rdata)
  );

  assign word_s = rdata;

  // Lane of a three-component step.
  always_comb begin
    case (op_q)
      chrt_pkg::OP_NS1, chrt_pkg::OP_NV1, chrt_pkg::OP_P1,
      chrt_pkg::OP_M01, chrt_pkg::OP_M11: lane = 2'd1;
      chrt_pkg::OP_NS2, chrt_pkg::OP_NV2, chrt_pkg::OP_P2,
      chrt_pkg::OP_M02, chrt_pkg::OP_M12: lane = 2'd2;
      default:                            lane = 2'd0;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = word_s;
    case (op_q)
      chrt_pkg::OP_NS0, chrt_pkg::OP_NS1, chrt_pkg::OP_NS2: mul_b = s_q[lane];
      chrt_pkg::OP_NV0, chrt_pkg::OP_NV1, chrt_pkg::OP_NV2: mul_b = v_q[lane];
      chrt_pkg::OP_P0, chrt_pkg::OP_P1, chrt_pkg::OP_P2: begin
        mul_a = W'({1'b0, q_q});
        mul_b = v_q[lane];
      end
      chrt_pkg::OP_M00, chrt_pkg::OP_M01, chrt_pkg::OP_M02,
      chrt_pkg::OP_M10, chrt_pkg::OP_M11, chrt_pkg::OP_M12: mul_b = r_q[lane];
      chrt_pkg::OP_W10, chrt_pkg::OP_W20: mul_b = chrt_pkg::sat32(m0_q);
      chrt_pkg::OP_W11, chrt_pkg::OP_W21: mul_b = chrt_pkg::sat32(m1_q);
      default: mul_b = '0;
    endcase
  end

  chrt_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign prod_x = AW'(prod);

  // Plane test: numerator, sign check and magnitudes for the divider.
  assign num_new  = -AW'(word_s) - num_q;
  assign plane_ok = (num_new != '0) && (den_q != '0) &&
                    ((num_new > 0) == (den_q > 0));
  assign div_a    = num_new[AW-1] ? chrt_pkg::MAG_W'(-num_new) : chrt_pkg::MAG_W'(num_new);
  assign div_b    = den_q[AW-1] ? chrt_pkg::DEN_W'(-den_q) : chrt_pkg::DEN_W'(den_q);
  assign div_start = (state_q == S_ACC) && (op_q == chrt_pkg::OP_D) && plane_ok;

  chrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (div_a),
    .b_i     (div_b),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // Hit point on one axis, then barycentric weights.
  assign p_sat = chrt_pkg::sat32(AW'(s_q[lane]) + prod_x);
  assign w0 = AW'(64'sd1 <<< chrt_pkg::FRAC_BITS) - w1_q - w2_q;
  assign inside_tri = !w0[AW-1] && !w1_q[AW-1] && !w2_q[AW-1];
  assign last_tri   = (tri_q + 1'b1) == tri_cnt_q;

  // A finished ray moves into the output register once it is free.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Output valid: set when a result is loaded, cleared by its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= chrt_pkg::OP_NS0;
      tri_q       <= '0;
      tri_cnt_q   <= '0;
      found_q     <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer && command_i == chrt_pkg::CMD_RAY) begin
            s_q[0] <= origin_x_i;
            s_q[1] <= origin_y_i;
            s_q[2] <= origin_z_i;
            v_q[0] <= dir_x_i;
            v_q[1] <= dir_y_i;
            v_q[2] <= dir_z_i;
            tri_q   <= '0;
            op_q    <= chrt_pkg::OP_NS0;
            found_q <= 1'b0;
            if (cfg_q > chrt_pkg::CNT_W'(chrt_pkg::MAX_TRIANGLES)) begin
              tri_cnt_q <= chrt_pkg::CNT_W'(chrt_pkg::MAX_TRIANGLES);
            end else begin
              tri_cnt_q <= cfg_q;
            end
            state_q <= (cfg_q == '0) ? S_DONE : S_RD;
          end
        end
        S_RD: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          op_q    <= chrt_pkg::op_e'(op_q + 5'd1);
          state_q <= S_RD;
          case (op_q)
            chrt_pkg::OP_NS0: num_q <= prod_x;
            chrt_pkg::OP_NV0: den_q <= prod_x;
            chrt_pkg::OP_NS1, chrt_pkg::OP_NS2: num_q <= num_q + prod_x;
            chrt_pkg::OP_NV1, chrt_pkg::OP_NV2: den_q <= den_q + prod_x;
            chrt_pkg::OP_D: begin
              if (plane_ok) begin
                state_q <= S_DIV;
              end else if (last_tri) begin
                state_q <= S_DONE;
              end else begin
                tri_q <= tri_q + 1'b1;
                op_q  <= chrt_pkg::OP_NS0;
              end
            end
            chrt_pkg::OP_P0, chrt_pkg::OP_P1, chrt_pkg::OP_P2:
              r_q[lane] <= chrt_pkg::sat32(AW'(p_sat) - AW'(word_s));
            chrt_pkg::OP_M00: m0_q <= prod_x;
            chrt_pkg::OP_M01, chrt_pkg::OP_M02: m0_q <= m0_q + prod_x;
            chrt_pkg::OP_M10: m1_q <= prod_x;
            chrt_pkg::OP_M11, chrt_pkg::OP_M12: m1_q <= m1_q + prod_x;
            chrt_pkg::OP_W10: w1_q <= prod_x;
            chrt_pkg::OP_W11: w1_q <= w1_q + prod_x;
            chrt_pkg::OP_W20: w2_q <= prod_x;
            chrt_pkg::OP_W21: w2_q <= w2_q + prod_x;
            default: begin
              // Color word: keep the nearest hit, earlier triangle on a tie.
              if (inside_tri && (!found_q || q_q < best_q)) begin
                found_q <= 1'b1;
                best_q  <= q_q;
                color_q <= rdata[chrt_pkg::COLOR_W-1:0];
              end
              if (last_tri) begin
                state_q <= S_DONE;
              end else begin
                tri_q <= tri_q + 1'b1;
                op_q  <= chrt_pkg::OP_NS0;
              end
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            q_q <= div_q;
            if (div_q != '0) begin
              op_q    <= chrt_pkg::OP_P0;
              state_q <= S_RD;
            end else if (last_tri) begin
              state_q <= S_DONE;
            end else begin
              tri_q   <= tri_q + 1'b1;
              op_q    <= chrt_pkg::OP_NS0;
              state_q <= S_RD;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            hit_q       <= found_q;
            out_color_q <= found_q ? color_q : '0;
            depth_q     <= found_q ? best_q : '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign ray_color_o = out_color_q;
  assign depth_o     = depth_q;

  // A reported hit always has a nonzero depth.
  a_hit_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> depth_o != '0)
    else $error("hit reported with zero depth");

  // A miss reports black at depth zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> ray_color_o == '0 && depth_o == '0)
    else $error("miss with nonzero color or depth");

  // The divider only finishes while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider result outside the divide wait");

  // A kept hit has a nonzero distance.
  a_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> best_q != '0)
    else $error("nearest hit kept with zero distance");

  // Triangle walk stays below the count.
  a_tri_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> tri_q < tri_cnt_q)
    else $error("triangle index beyond count");

endmodule

### tb/sv/tb_closest_hit_ray_triangle_caster.sv
// Self-checking testbench for the closest-hit ray/triangle caster.
// Depends on chrt_pkg and the closest_hit_ray_triangle_caster RTL; a built-in
// predictor works out each ray result, and a checker compares every output transfer.
module tb_closest_hit_ray_triangle_caster;

  localparam int  CYCLE_LIMIT = 3_000_000;
  localparam int  TRI_WORDS   = 18;
  localparam int  WIDE_TRIS   = 32;
  localparam real ONE_Q       = 65536.0;

  // One input item of the block.
  typedef struct {
    logic        cmd;
    logic [7:0]  tri_id;
    logic [4:0]  widx;
    logic [31:0] val;
    logic [31:0] ox, oy, oz;
    logic [31:0] dx, dy, dz;
  } cast_item_t;

  // One ray result.
  typedef struct {
    logic        hit;
    logic [23:0] color;
    logic [30:0] depth;
  } shade_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [chrt_pkg::CNT_W-1:0]     cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic                           command_i;
  logic [chrt_pkg::TRI_W-1:0]     tri_index_i;
  logic [chrt_pkg::WIDX_W-1:0]    word_index_i;
  logic signed [31:0]             word_value_i;
  logic signed [31:0]             origin_x_i, origin_y_i, origin_z_i;
  logic signed [31:0]             dir_x_i, dir_y_i, dir_z_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic                           hit_o;
  logic [chrt_pkg::COLOR_W-1:0]   ray_color_o;
  logic [chrt_pkg::Q_W-1:0]       depth_o;

  // Predictor state: shadow store, triangle count and pending shades.
  logic [31:0] shadow_store [chrt_pkg::STORE_DEPTH];
  logic [8:0]  tri_count;
  shade_t      pending_shades [$];
  real         tri_geom [chrt_pkg::MAX_TRIANGLES][9];

  int errors;
  int cycles;
  int send_idle_pct;
  int stall_pct;
  int hold_cycles;

  closest_hit_ray_triangle_caster u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .tri_index_i     (tri_index_i),
    .word_index_i    (word_index_i),
    .word_value_i    (word_value_i),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .origin_z_i      (origin_z_i),
    .dir_x_i         (dir_x_i),
    .dir_y_i         (dir_y_i),
    .dir_z_i         (dir_z_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .ray_color_o     (ray_color_o),
    .depth_o         (depth_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** closest_hit_ray_triangle_caster: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker: each output transfer against the oldest pending shade.
  always @(posedge clk_i) begin
    shade_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_shades.size() == 0) begin
        $error("unexpected result: hit=%0d color=%h depth=%h",
               hit_o, ray_color_o, depth_o);
        errors++;
      end else begin
        want = pending_shades.pop_front();
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit_o);
          errors++;
        end
        if (ray_color_o !== want.color) begin
          $error("ray_color: expected %h, got %h", want.color, ray_color_o);
          errors++;
        end
        if (depth_o !== want.depth) begin
          $error("depth: expected %h, got %h", want.depth, depth_o);
          errors++;
        end
      end
    end
  end

  // ---------------- Predictor ----------------

  function automatic longint word_of(int t, int k);
    return longint'(signed'(shadow_store[t * TRI_WORDS + k]));
  endfunction

  // Q16.16 product with floor rounding.
  function automatic longint qprod(longint a, longint b);
    return (a * b) >>> chrt_pkg::FRAC_BITS;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return -64'sh8000_0000;
    return x;
  endfunction

  function automatic longint dot_at(int t, int k, longint a0, longint a1, longint a2);
    return qprod(word_of(t, k), a0) + qprod(word_of(t, k + 1), a1) +
           qprod(word_of(t, k + 2), a2);
  endfunction

  // Ray parameter of a hit on triangle t, or zero for a miss.
  function automatic longint unsigned hit_depth(int t, longint s[3], longint v[3]);
    longint num, den, m0, m1, w0, w1, w2, p;
    longint rr[3];
    longint unsigned a, b, q, r;
    num = -word_of(t, 3) - dot_at(t, 0, s[0], s[1], s[2]);
    den = dot_at(t, 0, v[0], v[1], v[2]);
    if (den == 0 || num == 0) return 0;
    if ((num > 0) != (den > 0)) return 0;
    a = (num > 0) ? num : -num;
    b = (den > 0) ? den : -den;
    q = a / b;
    r = a % b;
    for (int i = 0; i < chrt_pkg::FRAC_BITS && q <= 64'h7FFF_FFFF; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= b) begin
        r = r - b;
        q = q | 1;
      end
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    if (q == 0) return 0;
    for (int i = 0; i < 3; i++) begin
      p = clamp32(s[i] + qprod(longint'(q), v[i]));
      rr[i] = clamp32(p - word_of(t, 4 + i));
    end
    m0 = clamp32(dot_at(t, 7, rr[0], rr[1], rr[2]));
    m1 = clamp32(dot_at(t, 10, rr[0], rr[1], rr[2]));
    w1 = qprod(word_of(t, 13), m0) + qprod(word_of(t, 14), m1);
    w2 = qprod(word_of(t, 15), m0) + qprod(word_of(t, 16), m1);
    w0 = (64'sd1 <<< chrt_pkg::FRAC_BITS) - w1 - w2;
    if (w0 < 0 || w1 < 0 || w2 < 0) return 0;
    return q;
  endfunction

  // Nearest hit over the active triangles; the lower index wins a tie.
  function automatic shade_t cast_ray(cast_item_t it);
    shade_t res;
    longint s[3], v[3];
    longint unsigned t, best;
    int n;
    s[0] = longint'(signed'(it.ox));
    s[1] = longint'(signed'(it.oy));
    s[2] = longint'(signed'(it.oz));
    v[0] = longint'(signed'(it.dx));
    v[1] = longint'(signed'(it.dy));
    v[2] = longint'(signed'(it.dz));
    res = '{hit: 1'b0, color: '0, depth: '0};
    best = 0;
    n = (tri_count > chrt_pkg::MAX_TRIANGLES) ? chrt_pkg::MAX_TRIANGLES : int'(tri_count);
    for (int i = 0; i < n; i++) begin
      t = hit_depth(i, s, v);
      if (t > 0 && (!res.hit || t < best)) begin
        res.hit = 1'b1;
        best = t;
        res.color = shadow_store[i * TRI_WORDS + 17][23:0];
      end
    end
    res.depth = best[30:0];
    return res;
  endfunction

  // Updates the shadow state for one accepted item.
  function automatic void apply_item(cast_item_t it);
    if (it.cmd == chrt_pkg::CMD_LOAD) begin
      if (it.widx < TRI_WORDS) shadow_store[int'(it.tri_id) * TRI_WORDS + it.widx] = it.val;
    end else begin
      pending_shades.push_back(cast_ray(it));
    end
  endfunction

  // ---------------- Drivers ----------------

  // Offers one item and waits for its transfer.
  task automatic send_item(cast_item_t it);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= it.cmd;
    tri_index_i  <= it.tri_id;
    word_index_i <= it.widx;
    word_value_i <= it.val;
    origin_x_i   <= it.ox;
    origin_y_i   <= it.oy;
    origin_z_i   <= it.oz;
    dir_x_i      <= it.dx;
    dir_y_i      <= it.dy;
    dir_z_i      <= it.dz;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_item(it);
  endtask

  // Stops offering and waits until every pending shade has arrived.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_shades.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_count(int value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= chrt_pkg::CNT_W'(value);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tri_count = 9'(value);
    @(posedge clk_i);
  endtask

  task automatic load_word(int t, int w, logic [31:0] value);
    cast_item_t it;
    it = '{cmd: chrt_pkg::CMD_LOAD, tri_id: 8'(t), widx: 5'(w), val: value,
           ox: $urandom(), oy: $urandom(), oz: $urandom(),
           dx: $urandom(), dy: $urandom(), dz: $urandom()};
    send_item(it);
  endtask

  task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    cast_item_t it;
    it = '{cmd: chrt_pkg::CMD_RAY, tri_id: 8'($urandom()), widx: 5'($urandom()),
           val: $urandom(), ox: ox, oy: oy, oz: oz, dx: dx, dy: dy, dz: dz};
    send_item(it);
  endtask

  // ---------------- Scene helpers ----------------

  function automatic logic [31:0] to_q(real x);
    return 32'($rtoi(x * ONE_Q));
  endfunction

  function automatic real rnd(real lo, real hi);
    return lo + (hi - lo) * $urandom_range(0, 100000) / 100000.0;
  endfunction

  // Writes a consistent triangle record from its first vertex and the edges leaving it.
  task automatic load_triangle(int t, real g[9], logic [31:0] color);
    real n0, n1, n2, g11, g12, g22, det;
    logic [31:0] rec [TRI_WORDS];
    n0 = g[4] * g[8] - g[5] * g[7];
    n1 = g[5] * g[6] - g[3] * g[8];
    n2 = g[3] * g[7] - g[4] * g[6];
    g11 = g[3] * g[3] + g[4] * g[4] + g[5] * g[5];
    g12 = g[3] * g[6] + g[4] * g[7] + g[5] * g[8];
    g22 = g[6] * g[6] + g[7] * g[7] + g[8] * g[8];
    det = g11 * g22 - g12 * g12;
    rec[0] = to_q(n0);
    rec[1] = to_q(n1);
    rec[2] = to_q(n2);
    rec[3] = to_q(-(n0 * g[0] + n1 * g[1] + n2 * g[2]));
    for (int i = 0; i < 3; i++) begin
      rec[4 + i]  = to_q(g[i]);
      rec[7 + i]  = to_q(g[3 + i]);
      rec[10 + i] = to_q(g[6 + i]);
    end
    rec[13] = to_q(g22 / det);
    rec[14] = to_q(-g12 / det);
    rec[15] = to_q(-g12 / det);
    rec[16] = to_q(g11 / det);
    rec[17] = color;
    for (int i = 0; i < 9; i++) tri_geom[t][i] = g[i];
    for (int w = 0; w < TRI_WORDS; w++) load_word(t, w, rec[w]);
  endtask

  // Random triangle, kept away from degenerate shapes; a few are pure noise.
  task automatic random_triangle(int t);
    real g[9];
    real g11, g12, g22;
    if ($urandom_range(0, 99) < 12) begin
      for (int w = 0; w < TRI_WORDS; w++) load_word(t, w, $urandom());
      for (int i = 0; i < 9; i++) tri_geom[t][i] = 0.0;
      return;
    end
    do begin
      for (int i = 0; i < 3; i++) g[i] = rnd(-6.0, 6.0);
      for (int i = 3; i < 9; i++) g[i] = rnd(-4.0, 4.0);
      g11 = g[3] * g[3] + g[4] * g[4] + g[5] * g[5];
      g12 = g[3] * g[6] + g[4] * g[7] + g[5] * g[8];
      g22 = g[6] * g[6] + g[7] * g[7] + g[8] * g[8];
    end while (g11 * g22 - g12 * g12 < 1.0);
    load_triangle(t, g, $urandom());
  endtask

  // Ray aimed near a point of triangle t; some rays are pure noise.
  task automatic aimed_ray(int t);
    real p[3], o[3], a, b, sc;
    if ($urandom_range(0, 99) < 10) begin
      send_ray($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      return;
    end
    a = rnd(-0.2, 1.0);
    b = rnd(-0.2, 1.0);
    sc = rnd(0.1, 3.0);
    for (int i = 0; i < 3; i++) begin
      p[i] = tri_geom[t][i] + a * tri_geom[t][3 + i] + b * tri_geom[t][6 + i];
      o[i] = rnd(-12.0, 12.0);
    end
    send_ray(to_q(o[0]), to_q(o[1]), to_q(o[2]),
             to_q((p[0] - o[0]) * sc), to_q((p[1] - o[1]) * sc), to_q((p[2] - o[2]) * sc));
  endtask

  // ---------------- Tests ----------------

  // No triangles active: every ray misses.
  task automatic test_empty_count();
    send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
    set_count(0);
    send_ray(to_q(1.0), to_q(1.0), 32'h0, 32'h0, 32'h0, to_q(1.0));
  endtask

  // Two equal squares-corner triangles at z = 5, then the special cases.
  task automatic test_directed();
    real g[9];
    g = '{0.0, 0.0, 5.0, 4.0, 0.0, 0.0, 0.0, 4.0, 0.0};
    load_triangle(0, g, 32'hFF12_3456);
    load_triangle(1, g, 32'h00AB_CDEF);
    load_word(2, 31, 32'hFFFF_FFFF);
    load_word(255, 18, 32'h8000_0000);
    set_count(2);
    // Plain hit; the tie goes to the first triangle.
    send_ray(to_q(1.0), to_q(1.0), 32'h0, 32'h0, 32'h0, to_q(1.0));
    // Parallel ray.
    send_ray(to_q(1.0), to_q(1.0), 32'h0, to_q(1.0), 32'h0, 32'h0);
    // Plane behind the origin.
    send_ray(to_q(1.0), to_q(1.0), 32'h0, 32'h0, 32'h0, to_q(-1.0));
    // Depth that truncates to zero.
    send_ray(to_q(1.0), to_q(1.0), to_q(5.0) - 1, 32'h0, 32'h0, to_q(2.0));
    // Origin on the plane.
    send_ray(to_q(1.0), to_q(1.0), to_q(5.0), 32'h0, 32'h0, to_q(1.0));
    // Saturated depth on both triangles.
    send_ray(to_q(1.0), to_q(1.0), 32'h0, 32'h0, 32'h0, 32'h1);
    // Outside the triangle.
    send_ray(to_q(3.5), to_q(3.5), 32'h0, 32'h0, 32'h0, to_q(1.0));
    // Extreme field values.
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // Extreme record words.
    load_word(1, 3, 32'h8000_0000);
    load_word(1, 13, 32'h7FFF_FFFF);
    send_ray(to_q(1.0), to_q(1.0), 32'h0, 32'h0, 32'h0, to_q(1.0));
    send_ray(to_q(0.5), to_q(0.5), to_q(9.0), 32'h0, 32'h0, to_q(-0.5));
  endtask

  // Random scenes of a few triangles under one idling mode.
  task automatic test_random_scenes(int idle_pct, int stall, int scenes);
    int n;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int sc = 0; sc < scenes; sc++) begin
      n = $urandom_range(1, 6);
      for (int t = 0; t < n; t++) random_triangle(t);
      set_count(n);
      for (int r = 0; r < 14; r++) begin
        if ($urandom_range(0, 99) < 8) load_word($urandom_range(0, 255), $urandom_range(18, 31),
                                                $urandom());
        if ($urandom_range(0, 99) < 5) random_triangle($urandom_range(0, n - 1));
        aimed_ray($urandom_range(0, n - 1));
      end
    end
    drain();
  endtask

  // Long output hold-off while rays keep coming, then a pause until empty and a second batch.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    random_triangle(0);
    random_triangle(1);
    set_count(2);
    hold_cycles = 600;
    for (int r = 0; r < 12; r++) aimed_ray($urandom_range(0, 1));
    drain();
    for (int r = 0; r < 6; r++) aimed_ray($urandom_range(0, 1));
    drain();
  endtask

  // A larger scene walked in full, then with one triangle fewer.
  task automatic test_wide_scene();
    send_idle_pct = 0;
    stall_pct     = 30;
    for (int t = 0; t < WIDE_TRIS; t++) random_triangle(t);
    set_count(WIDE_TRIS);
    for (int r = 0; r < 4; r++) aimed_ray($urandom_range(0, WIDE_TRIS - 1));
    set_count(WIDE_TRIS - 1);
    aimed_ray($urandom_range(0, WIDE_TRIS - 2));
    drain();
  endtask

  // ---------------- Sequence ----------------

  initial begin
    errors        = 0;
    cycles        = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    tri_count     = '0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = chrt_pkg::CMD_LOAD;
    tri_index_i   = '0;
    word_index_i  = '0;
    word_value_i  = '0;
    origin_x_i    = '0;
    origin_y_i    = '0;
    origin_z_i    = '0;
    dir_x_i       = '0;
    dir_y_i       = '0;
    dir_z_i       = '0;
    out_ready_i   = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_count();
    test_directed();
    test_random_scenes(0, 0, 2);
    test_random_scenes(75, 0, 2);
    test_random_scenes(0, 75, 2);
    test_random_scenes(8, 8, 2);
    test_backpressure();
    test_wide_scene();

    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("** closest_hit_ray_triangle_caster: PASSED **");
    end else begin
      $display("** closest_hit_ray_triangle_caster: FAILED **");
    end
    $finish;
  end

endmodule
